// ----- sv/mmed_pkg.sv -----
package mmed_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_RESULTS = 33;

    localparam int COL_W   = 12;
    localparam int CCNT_W  = 13;
    localparam int IDX_W   = 24;
    localparam int ROW_W   = 13;
    localparam int HH_W    = 12;
    localparam int STEP_W  = 32;
    localparam int OFS_W   = 16;
    localparam int FRAC_W  = 16;
    // (column + offset) * step: 17-bit index times 32-bit step
    localparam int POS_W   = 49;
    localparam int RES_W   = 6;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int OUT_W   = 40;

    localparam logic [2:0] REG_BIN_STEP     = 3'd0;
    localparam logic [2:0] REG_PIXEL_OFFSET = 3'd1;
    localparam logic [2:0] REG_COLUMN_COUNT = 3'd2;
    localparam logic [2:0] REG_SAMPLE_TOTAL = 3'd3;
    localparam logic [2:0] REG_HALF_HEIGHT  = 3'd4;

    localparam logic [SAMPLE_BITS:0] FULL_SCALE = (SAMPLE_BITS+1)'(1) << (SAMPLE_BITS - 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [STEP_W-1:0] bin_step;
        logic [OFS_W-1:0]  pixel_offset;
        logic [CCNT_W-1:0] column_count;
        logic [IDX_W-1:0]  sample_total;
        logic [HH_W-1:0]   half_height;
    } cfg_t;

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_START = 8'b0000_0010,
        ST_OPEN  = 8'b0000_0100,
        ST_PRIME = 8'b0000_1000,
        ST_CHECK = 8'b0001_0000,
        ST_RUN   = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic init;
        logic start;
        logic open;
        logic prime;
        logic take;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic pending;
        logic cap;
        logic close_next;
        logic last;
        logic out_free;
    } sts_t;

    // row = (half_height * (full_scale - v)) >> (SAMPLE_BITS-1), kept to 13 bits
    function automatic logic [ROW_W-1:0] row_of(input logic [HH_W-1:0] hh, input sample_t v);
        logic [SAMPLE_BITS:0]      span;
        logic [HH_W+SAMPLE_BITS:0] prod;
        span = FULL_SCALE - {v[SAMPLE_BITS-1], v};
        prod = (HH_W+SAMPLE_BITS+1)'(hh) * (HH_W+SAMPLE_BITS+1)'(span);
        return prod[SAMPLE_BITS-1 +: ROW_W];
    endfunction

endpackage

// ----- sv/mmed_regs.sv -----
module mmed_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mmed_pkg::ADDR_W-1:0] paddr,
    input  logic [mmed_pkg::DATA_W-1:0] pwdata,
    output logic [mmed_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output mmed_pkg::cfg_t              cfg,
    output logic                        restart
);
    import mmed_pkg::*;

    cfg_t       cfg_reg;
    logic       wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr      = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // any write to a known register restarts the pass
    always_comb begin
        unique case (reg_idx)
            REG_BIN_STEP, REG_PIXEL_OFFSET, REG_COLUMN_COUNT,
            REG_SAMPLE_TOTAL, REG_HALF_HEIGHT: restart = wr;
            default: restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bin_step     <= STEP_W'(65536);
            cfg_reg.pixel_offset <= '0;
            cfg_reg.column_count <= CCNT_W'(1024);
            cfg_reg.sample_total <= IDX_W'(1024);
            cfg_reg.half_height  <= HH_W'(128);
        end else if (wr) begin
            unique case (reg_idx)
                REG_BIN_STEP:     cfg_reg.bin_step     <= pwdata[STEP_W-1:0];
                REG_PIXEL_OFFSET: cfg_reg.pixel_offset <= pwdata[OFS_W-1:0];
                REG_COLUMN_COUNT: cfg_reg.column_count <= pwdata[CCNT_W-1:0];
                REG_SAMPLE_TOTAL: cfg_reg.sample_total <= pwdata[IDX_W-1:0];
                REG_HALF_HEIGHT:  cfg_reg.half_height  <= pwdata[HH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BIN_STEP:     prdata = DATA_W'(cfg_reg.bin_step);
            REG_PIXEL_OFFSET: prdata = DATA_W'(cfg_reg.pixel_offset);
            REG_COLUMN_COUNT: prdata = DATA_W'(cfg_reg.column_count);
            REG_SAMPLE_TOTAL: prdata = DATA_W'(cfg_reg.sample_total);
            REG_HALF_HEIGHT:  prdata = DATA_W'(cfg_reg.half_height);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- sv/mmed_ctrl.sv -----
module mmed_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           restart,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mmed_pkg::sts_t sts,
    output mmed_pkg::cmd_t cmd
);
    import mmed_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_RUN) || (state_reg == ST_DONE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = ST_OPEN;
            end
            ST_OPEN: begin
                cmd.open   = 1'b1;
                state_next = ST_PRIME;
            end
            ST_PRIME: begin
                cmd.prime  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // a full burst of results waits for the next word
                state_next = (sts.pending && !sts.cap) ? ST_EMIT : ST_RUN;
            end
            ST_RUN: begin
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = sts.close_next ? ST_EMIT : ST_RUN;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last ? ST_DONE : ST_OPEN;
                end
            end
            ST_DONE: ;
            default: state_next = ST_INIT;
        endcase
        if (restart) begin
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/mmed_dp.sv -----
module mmed_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mmed_pkg::cfg_t                   cfg,
    input  mmed_pkg::cmd_t                   cmd,
    output mmed_pkg::sts_t                   sts,
    input  logic [mmed_pkg::SAMPLE_BITS-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mmed_pkg::OUT_W-1:0]       m_tdata,
    output logic                             m_tlast
);
    import mmed_pkg::*;

    logic [POS_W-1:0]  pos_reg;      // raw start of the current bin, Q16
    logic [POS_W:0]    end_reg;      // raw end of the current bin, Q16
    logic [IDX_W-1:0]  s_reg;
    logic [IDX_W-1:0]  elo_reg;
    logic [IDX_W-1:0]  e_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [COL_W-1:0]  col_reg;
    logic [RES_W-1:0]  res_cnt_reg;
    sample_t           held_reg;
    sample_t           max_reg;
    sample_t           min_reg;

    logic              m_tvalid_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [ROW_W-1:0]  m_top_reg;
    logic [ROW_W-1:0]  m_bot_reg;
    logic              m_last_reg;

    logic [IDX_W-1:0]         t_eff;
    logic [IDX_W-1:0]         t_max;
    logic [CCNT_W-1:0]        cols_eff;
    logic [IDX_W-1:0]         idx_inc;
    logic [IDX_W-1:0]         s_inc;
    logic [IDX_W-1:0]         s_next;
    logic [IDX_W-1:0]         elo_next;
    logic [IDX_W-1:0]         e_next;
    logic [STEP_W+OFS_W-1:0]  ofs_prod;
    logic [POS_W-FRAC_W-1:0]  start_raw;
    logic [POS_W-FRAC_W:0]    end_raw;
    sample_t                  v;

    assign v        = sample_t'(s_tdata);
    assign t_eff    = (cfg.sample_total == '0) ? IDX_W'(1) : cfg.sample_total;
    assign t_max    = t_eff - IDX_W'(1);
    assign idx_inc  = idx_reg + IDX_W'(1);
    assign s_inc    = s_reg + IDX_W'(1);
    assign ofs_prod = (STEP_W+OFS_W)'(cfg.pixel_offset) * (STEP_W+OFS_W)'(cfg.bin_step);

    always_comb begin
        priority if (cfg.column_count == '0) begin
            cols_eff = CCNT_W'(1);
        end else if (cfg.column_count > CCNT_W'(MAX_COLUMNS)) begin
            cols_eff = CCNT_W'(MAX_COLUMNS);
        end else begin
            cols_eff = cfg.column_count;
        end
    end

    // bin limits, clamped to the stream
    always_comb begin
        start_raw = pos_reg[POS_W-1:FRAC_W];
        end_raw   = end_reg[POS_W:FRAC_W];
        s_next    = (start_raw > (POS_W-FRAC_W)'(t_max)) ? t_max : start_raw[IDX_W-1:0];
        elo_next  = (end_raw > (POS_W-FRAC_W+1)'(t_eff)) ? t_eff : end_raw[IDX_W-1:0];
        e_next    = (elo_reg < s_inc) ? s_inc : elo_reg;
    end

    always_comb begin
        sts.pending    = e_reg <= idx_reg;
        sts.cap        = res_cnt_reg == RES_W'(MAX_RESULTS);
        sts.close_next = (idx_reg < t_eff) ? (e_reg <= idx_inc) : (e_reg <= idx_reg);
        sts.last       = ({1'b0, col_reg} + CCNT_W'(1)) >= cols_eff;
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            pos_reg     <= POS_W'(ofs_prod);
            idx_reg     <= '0;
            col_reg     <= '0;
            res_cnt_reg <= '0;
            held_reg    <= '0;
        end else if (cmd.start) begin
            end_reg <= (POS_W+1)'(pos_reg) + (POS_W+1)'(cfg.bin_step);
        end else if (cmd.open) begin
            s_reg   <= s_next;
            elo_reg <= elo_next;
            max_reg <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            min_reg <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (cmd.prime) begin
            e_reg <= e_next;
            // a new bin that starts behind the stream picks up the last word seen
            if ((idx_reg != '0) && (s_reg < idx_reg)) begin
                if (held_reg > max_reg) max_reg <= held_reg;
                if (held_reg < min_reg) min_reg <= held_reg;
            end
        end else if (cmd.take) begin
            res_cnt_reg <= '0;
            if (idx_reg < t_eff) begin
                if ((e_reg > idx_reg) && (s_reg <= idx_reg)) begin
                    if (v > max_reg) max_reg <= v;
                    if (v < min_reg) min_reg <= v;
                end
                held_reg <= v;
                idx_reg  <= idx_inc;
            end
        end else if (cmd.emit) begin
            res_cnt_reg <= res_cnt_reg + RES_W'(1);
            if (!sts.last) begin
                col_reg <= col_reg + COL_W'(1);
                pos_reg <= pos_reg + POS_W'(cfg.bin_step);
                end_reg <= end_reg + (POS_W+1)'(cfg.bin_step);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_col_reg  <= col_reg;
            m_top_reg  <= row_of(cfg.half_height, max_reg);
            m_bot_reg  <= row_of(cfg.half_height, min_reg);
            m_last_reg <= sts.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_W-COL_W-2*ROW_W)'(0), m_bot_reg, m_top_reg, m_col_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ----- sv/minmax_envelope_decimator.sv -----
// channel   | dir | word
// s_        | in  | s_tdata[15:0] sample (Q1.15)
// m_        | out | m_tdata column[11:0], top_row[24:12], bottom_row[37:25]; m_tlast last_column
// apb       | in  | five config registers at byte addresses 0,4,8,12,16
//
// A sample takes one cycle while no column closes. Each column emitted passes the
// sequencer through emit, open, prime and check before the next sample is taken.
// Reset (aresetn low, synchronous) or any register write restarts the pass: init,
// start, open, prime and check run with s_tready low. A result waits in the output
// register while m_tready is low; samples keep flowing until the next column needs it.
module minmax_envelope_decimator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mmed_pkg::SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mmed_pkg::OUT_W-1:0]       m_tdata,   // column, top_row, bottom_row
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmed_pkg::ADDR_W-1:0]      paddr,
    input  logic [mmed_pkg::DATA_W-1:0]      pwdata,
    output logic [mmed_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import mmed_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic restart;

    mmed_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    mmed_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (restart),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mmed_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- sv/mmed_checker.sv -----
module mmed_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mmed_pkg::OUT_W-1:0]       m_tdata,
    input logic                             m_tlast,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [mmed_pkg::ADDR_W-1:0]      paddr,
    input logic                             pready
);
    import mmed_pkg::*;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] <= REG_HALF_HEIGHT);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed under stall");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

    // a register write restarts the pass, so input stalls next cycle
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_tready)
        else $error("input taken straight after a register write");

    // nothing follows the final column of a pass
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after final column");

endmodule

bind minmax_envelope_decimator mmed_checker u_mmed_checker (.*);
